### src/command_frame_deframer_popcount_check_macros.svh
// Assertion macros shared by the deframer RTL.
`ifndef COMMAND_FRAME_DEFRAMER_POPCOUNT_CHECK_MACROS_SVH
`define COMMAND_FRAME_DEFRAMER_POPCOUNT_CHECK_MACROS_SVH

// Clocked check, held off while reset is high.
`define CFDPC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define CFDPC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### src/cfdpc_pkg.sv
// Types, constants and helpers for the command frame deframer.
`timescale 1ns / 1ps
`default_nettype none

package cfdpc_pkg;

   // header (5 bytes) plus check byte
   localparam logic [15:0] HDR_AND_CHECK = 16'd6;

   localparam int RSP_DATA_W = 48;

   typedef enum logic [6:0] {
      PH_CNT_LO  = 7'b0000001,
      PH_CNT_HI  = 7'b0000010,
      PH_FLAGS   = 7'b0000100,
      PH_LEN_LO  = 7'b0001000,
      PH_LEN_HI  = 7'b0010000,
      PH_PAYLOAD = 7'b0100000,
      PH_CHECK   = 7'b1000000
   } phase_type;

   typedef struct packed {
      logic        out_kind;
      logic [7:0]  payload_byte;
      logic [15:0] pkt_count;
      logic        drive_flag;
      logic        status_flag;
      logic        sleep_flag;
      logic        ack_flag;
      logic [15:0] frame_length;
      logic        check_ok;
      logic        length_error;
   } rsp_type;

   function automatic logic [3:0] popcount8(input logic [7:0] v);
      logic [3:0] n;
      n = 4'd0;
      for (int i = 0; i < 8; i++) begin
         n = n + {3'b000, v[i]};
      end
      return n;
   endfunction

   // lowest bit first: payload_byte, pkt_count, drive, status, sleep, ack,
   // frame_length, check_ok, length_error, zero fill
   function automatic logic [RSP_DATA_W-1:0] pack_tdata(input rsp_type r);
      return {2'b00, r.length_error, r.check_ok, r.frame_length,
              r.ack_flag, r.sleep_flag, r.status_flag, r.drive_flag,
              r.pkt_count, r.payload_byte};
   endfunction

endpackage

`default_nettype wire

### src/cfdpc_parse.sv
// Frame parser: phase tracking, header capture, popcount sum and result build.
`timescale 1ns / 1ps
`default_nettype none

`include "command_frame_deframer_popcount_check_macros.svh"

module cfdpc_parse (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             step,
   input  wire logic [7:0]       rx_byte,
   output logic                  res_valid,
   output cfdpc_pkg::rsp_type    res
);
   import cfdpc_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [15:0] remain_ff, remain_in;
   logic [15:0] count_ff, count_in;
   logic [3:0]  flag_ff, flag_in;
   logic [15:0] length_ff, length_in;
   logic [7:0]  sum_ff, sum_in;
   logic [3:0]  pc;
   logic [15:0] len_word;
   logic [7:0]  sum_add;
   logic        summary;
   logic        ok;
   logic        err;

   assign pc       = popcount8(rx_byte);
   assign sum_add  = sum_ff + {4'b0000, pc};
   assign len_word = {rx_byte, length_ff[7:0]};

   always_comb begin
      phase_in  = phase_ff;
      remain_in = remain_ff;
      count_in  = count_ff;
      flag_in   = flag_ff;
      length_in = length_ff;
      sum_in    = sum_ff;
      res_valid = 1'b0;
      summary   = 1'b0;
      ok        = 1'b0;
      err       = 1'b0;
      case (phase_ff)
         PH_CNT_HI: begin
            count_in = {rx_byte, count_ff[7:0]};
            sum_in   = sum_add;
            phase_in = PH_FLAGS;
         end
         PH_FLAGS: begin
            flag_in  = rx_byte[3:0];
            sum_in   = sum_add;
            phase_in = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            length_in = {8'h00, rx_byte};
            sum_in    = sum_add;
            phase_in  = PH_LEN_HI;
         end
         PH_LEN_HI: begin
            length_in = len_word;
            sum_in    = sum_add;
            if (len_word < HDR_AND_CHECK) begin
               // short frame: report and resync
               res_valid = 1'b1;
               summary   = 1'b1;
               err       = 1'b1;
               phase_in  = PH_CNT_LO;
            end else begin
               remain_in = len_word - HDR_AND_CHECK;
               phase_in  = (len_word == HDR_AND_CHECK) ? PH_CHECK : PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            sum_in    = sum_add;
            remain_in = remain_ff - 16'd1;
            res_valid = 1'b1;
            if (remain_ff == 16'd1) begin
               phase_in = PH_CHECK;
            end
         end
         PH_CHECK: begin
            res_valid = 1'b1;
            summary   = 1'b1;
            ok        = (sum_ff == rx_byte);
            phase_in  = PH_CNT_LO;
         end
         default: begin
            // count low byte opens a new frame
            count_in  = {8'h00, rx_byte};
            flag_in   = 4'h0;
            length_in = 16'h0000;
            remain_in = 16'h0000;
            sum_in    = {4'b0000, pc};
            phase_in  = PH_CNT_HI;
         end
      endcase
   end

   always_comb begin
      res = '0;
      if (summary) begin
         res.out_kind     = 1'b1;
         res.pkt_count    = count_ff;
         res.drive_flag   = flag_ff[0];
         res.status_flag  = flag_ff[1];
         res.sleep_flag   = flag_ff[2];
         res.ack_flag     = flag_ff[3];
         res.frame_length = length_in;
         res.check_ok     = ok;
         res.length_error = err;
      end else begin
         res.payload_byte = rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_CNT_LO;
         remain_ff <= 16'h0000;
         count_ff  <= 16'h0000;
         flag_ff   <= 4'h0;
         length_ff <= 16'h0000;
         sum_ff    <= 8'h00;
      end else if (step) begin
         phase_ff  <= phase_in;
         remain_ff <= remain_in;
         count_ff  <= count_in;
         flag_ff   <= flag_in;
         length_ff <= length_in;
         sum_ff    <= sum_in;
      end
   end

   `CFDPC_ASSERT(a_payload_phase, clock, reset, (res_valid && !res.out_kind) |-> (phase_ff == PH_PAYLOAD), "payload word outside payload phase")
   `CFDPC_ASSERT(a_err_not_ok, clock, reset, (res_valid && res.length_error) |-> (!res.check_ok && phase_ff == PH_LEN_HI), "length error summary malformed")
   `CFDPC_ASSERT(a_check_resync, clock, reset, (step && phase_ff == PH_CHECK) |=> (phase_ff == PH_CNT_LO), "no resync after check byte")
   `CFDPC_ASSERT(a_last_payload, clock, reset, (step && phase_ff == PH_PAYLOAD && remain_ff == 16'd1) |=> (phase_ff == PH_CHECK), "last payload word did not reach check")

endmodule

`default_nettype wire

### src/cfdpc_out_reg.sv
// Result register on the master side of the stream.
`timescale 1ns / 1ps
`default_nettype none

`include "command_frame_deframer_popcount_check_macros.svh"

module cfdpc_out_reg (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  load,
   input  wire cfdpc_pkg::rsp_type                    res,
   output logic                                       free,
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   output logic [cfdpc_pkg::RSP_DATA_W-1:0]           rsp_tdata,
   output logic                                       rsp_tuser
);
   import cfdpc_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   assign free     = !valid_ff || rsp_tready;
   assign valid_in = load || (valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= res;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = pack_tdata(data_ff);
   assign rsp_tuser  = data_ff.out_kind;

   `CFDPC_ASSERT(a_no_overwrite, clock, reset, load |-> free, "result word overwritten while stalled")
   `CFDPC_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_tvalid, "result valid right after reset")

endmodule

`default_nettype wire

### src/command_frame_deframer_popcount_check.sv
// Top level of the command frame deframer with popcount check.
//
//  channel | dir | handshake             | payload
//  req     | in  | req_tvalid/req_tready | tdata[7:0] rx_byte
//  rsp     | out | rsp_tvalid/rsp_tready | tuser out_kind, tdata result fields
//
// One byte per cycle while no result stalls: a word is registered in the input
// register, passes through the parser and is registered in the result register.
// Reset is synchronous and clears the parser to wait for a count low byte.
// A stalled result holds the result register; the input register still takes
// one more word, and words that give no result keep moving during a stall.
`timescale 1ns / 1ps
`default_nettype none

module command_frame_deframer_popcount_check (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [7:0]                        req_tdata,   // [7:0] rx_byte
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // [7:0] payload_byte, [23:8] pkt_count, [24] drive_flag, [25] status_flag,
   // [26] sleep_flag, [27] ack_flag, [43:28] frame_length, [44] check_ok,
   // [45] length_error, [47:46] zero
   output logic [cfdpc_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   output logic                                   rsp_tuser    // [0] out_kind
);
   import cfdpc_pkg::*;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       req_accept;
   logic       advance;
   logic       res_valid;
   rsp_type    res;
   logic       out_free;

   assign req_accept  = req_tvalid && req_tready;
   assign advance     = in_valid_ff && (!res_valid || out_free);
   assign req_tready  = !in_valid_ff || advance;
   assign in_valid_in = req_accept || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_byte_ff <= req_tdata;
      end
   end

   cfdpc_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .rx_byte   (in_byte_ff),
      .res_valid (res_valid),
      .res       (res)
   );

   cfdpc_out_reg u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (advance && res_valid),
      .res        (res),
      .free       (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire
